### rtl/flow_statistics_table_defines.svh
// assertion macros shared by the flow table rtl
`ifndef FLOW_STATISTICS_TABLE_DEFINES_SVH
`define FLOW_STATISTICS_TABLE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define FST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/fst_pkg.sv
package fst_pkg;

  // default table depth
  localparam int DEFAULT_MAX_FLOWS = 256;

  // event codes (code 1 and codes 5..7 only touch last time and total)
  localparam logic [2:0] EV_SEND = 3'd0;
  localparam logic [2:0] EV_PROC = 3'd2;
  localparam logic [2:0] EV_RECV = 3'd3;
  localparam logic [2:0] EV_LOST = 3'd4;

  // in-flight saturation limits
  localparam logic signed [31:0] IN_FLIGHT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] IN_FLIGHT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_DROPPED  = 2'd2
  } fst_status_t;

  // input beat
  typedef struct packed {
    logic [31:0] flow_id;
    logic [2:0]  event_code;
    logic [31:0] timestamp;
    logic [15:0] source_node;
    logic [15:0] dest_node;
  } fst_in_t;

  // result beat
  typedef struct packed {
    fst_status_t        status;
    logic signed [31:0] in_flight;
    logic [31:0]        packets_total;
    logic [31:0]        packets_processed;
    logic [31:0]        packets_sent;
    logic [31:0]        packets_lost;
    logic [31:0]        first_time;
    logic [31:0]        last_time;
    logic [15:0]        flow_source;
    logic [15:0]        flow_dest;
    logic [8:0]         flows_known;
  } fst_out_t;

  // one flow record
  typedef struct packed {
    logic signed [31:0] in_flight;
    logic [31:0]        total;
    logic [31:0]        processed;
    logic [31:0]        sent;
    logic [31:0]        lost;
    logic [31:0]        first_time;
    logic [31:0]        last_time;
    logic [15:0]        source;
    logic [15:0]        dest;
  } fst_rec_t;

  // event walking down the cell row, with the record it picked up
  typedef struct packed {
    fst_in_t     ev;
    logic        done;
    fst_status_t status;
    fst_rec_t    rec;
  } fst_beat_t;

endpackage

### rtl/fst_cell.sv
`include "flow_statistics_table_defines.svh"

module fst_cell
  import fst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv_i,
  input  logic      prev_valid_i,
  input  logic      beat_vld_i,
  input  fst_beat_t beat_i,
  output logic      beat_vld_o,
  output fst_beat_t beat_o,
  output logic      valid_o
);

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  logic      valid_r, valid_nxt;
  logic [31:0] key_r, key_nxt;
  fst_rec_t  rec_r, rec_nxt;
  fst_beat_t beat_r, beat_nxt;
  logic      beat_vld_r, beat_vld_nxt;

  logic      live;
  logic      hit;
  logic      ins;
  fst_rec_t  base;
  fst_rec_t  upd;

  // match against the stored key, or claim this slot as the first free one
  assign live = beat_vld_i && !beat_i.done;
  assign hit  = live && valid_r && (key_r == beat_i.ev.flow_id);
  assign ins  = live && !valid_r;

  // record update for this beat
  always_comb begin
    base = rec_r;
    if (!valid_r) begin
      base            = '0;
      base.first_time = beat_i.ev.timestamp;
      base.source     = beat_i.ev.source_node;
      base.dest       = beat_i.ev.dest_node;
    end
    upd           = base;
    upd.last_time = beat_i.ev.timestamp;
    upd.total     = sat_inc(base.total);
    case (beat_i.ev.event_code)
      EV_SEND: begin
        upd.processed = sat_inc(base.processed);
        upd.sent      = sat_inc(base.sent);
        if (base.in_flight != IN_FLIGHT_MAX) begin
          upd.in_flight = base.in_flight + 32'sd1;
        end
      end
      EV_PROC: begin
        upd.processed = sat_inc(base.processed);
      end
      EV_RECV: begin
        upd.processed = sat_inc(base.processed);
        if (base.in_flight != IN_FLIGHT_MIN) begin
          upd.in_flight = base.in_flight - 32'sd1;
        end
      end
      EV_LOST: begin
        upd.lost = sat_inc(base.lost);
        if (base.in_flight != IN_FLIGHT_MIN) begin
          upd.in_flight = base.in_flight - 32'sd1;
        end
      end
      default: begin
      end
    endcase
  end

  // next state of the slot and of the passing beat
  always_comb begin
    valid_nxt    = valid_r;
    key_nxt      = key_r;
    rec_nxt      = rec_r;
    beat_nxt     = beat_r;
    beat_vld_nxt = beat_vld_r;
    if (adv_i) begin
      beat_nxt     = beat_i;
      beat_vld_nxt = beat_vld_i;
      if (hit || ins) begin
        rec_nxt         = upd;
        beat_nxt.done   = 1'b1;
        beat_nxt.status = hit ? ST_UPDATED : ST_INSERTED;
        beat_nxt.rec    = upd;
      end
      if (ins) begin
        valid_nxt = 1'b1;
        key_nxt   = beat_i.ev.flow_id;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      beat_vld_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      beat_vld_r <= beat_vld_nxt;
    end
  end

  // slot contents and beat payload
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    rec_r  <= rec_nxt;
    beat_r <= beat_nxt;
  end

  assign beat_vld_o = beat_vld_r;
  assign beat_o     = beat_r;
  assign valid_o    = valid_r;

  // slots fill in order and never empty
  `FST_ASSERT_NOW(a_prefix_fill, valid_r, prev_valid_i, "slot valid ahead of predecessor")
  `FST_ASSERT_NEXT(a_slot_sticky, valid_r, valid_r, "valid slot was lost")

endmodule

### rtl/flow_statistics_table.sv
// Per-flow packet counter table. Each input beat is a trace event that walks a row of
// MAX_FLOWS cells, one cell per clock while the row is not stalled; each cell holds one flow
// record, matches the event's flow id, or takes the event as a new flow if it is the first
// empty cell. A new event may enter every cycle the row is not stalled, so the sustained
// rate is one event per cycle; each result passes the MAX_FLOWS cell registers, then the
// output register. Results leave in input order. When all cells are taken, an event for an
// unknown flow comes out with status dropped and zero record fields. Counters saturate. A
// result held in the output register by out_ready low stalls the whole row and the input.
`include "flow_statistics_table_defines.svh"

module flow_statistics_table
  import fst_pkg::*;
#(
  parameter int MAX_FLOWS = DEFAULT_MAX_FLOWS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fst_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output fst_out_t out_data
);

  localparam int CNT_W = $clog2(MAX_FLOWS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_FLOWS);

  logic                adv;
  logic                beat_vld_w [MAX_FLOWS+1];
  fst_beat_t           beat_w     [MAX_FLOWS+1];
  logic                slot_vld_w [MAX_FLOWS+1];
  fst_beat_t           tail;
  logic                tail_vld;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  fst_out_t            out_data_r, out_data_nxt;
  logic [CNT_W+8:0]    cnt_wide;
  logic                out_drop;

  // row advances whenever the result register is free or being drained
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // head of the row
  always_comb begin
    beat_w[0]        = '0;
    beat_w[0].ev     = in_data;
    beat_w[0].done   = 1'b0;
    beat_w[0].status = ST_DROPPED;
  end
  assign beat_vld_w[0] = in_valid;
  assign slot_vld_w[0] = 1'b1;

  // cell row
  for (genvar i = 0; i < MAX_FLOWS; i++) begin : g_cell
    fst_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .adv_i        (adv),
      .prev_valid_i (slot_vld_w[i]),
      .beat_vld_i   (beat_vld_w[i]),
      .beat_i       (beat_w[i]),
      .beat_vld_o   (beat_vld_w[i+1]),
      .beat_o       (beat_w[i+1]),
      .valid_o      (slot_vld_w[i+1])
    );
  end

  assign tail     = beat_w[MAX_FLOWS];
  assign tail_vld = beat_vld_w[MAX_FLOWS];

  // flow count after each result, then the result beat
  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (tail_vld && tail.done && (tail.status == ST_INSERTED)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    cnt_wide = {9'd0, cnt_nxt};
    if (adv) begin
      out_valid_nxt                  = tail_vld;
      out_data_nxt                   = '0;
      out_data_nxt.status            = tail.done ? tail.status : ST_DROPPED;
      out_data_nxt.flows_known       = cnt_wide[8:0];
      if (tail.done) begin
        out_data_nxt.in_flight         = tail.rec.in_flight;
        out_data_nxt.packets_total     = tail.rec.total;
        out_data_nxt.packets_processed = tail.rec.processed;
        out_data_nxt.packets_sent      = tail.rec.sent;
        out_data_nxt.packets_lost      = tail.rec.lost;
        out_data_nxt.first_time        = tail.rec.first_time;
        out_data_nxt.last_time         = tail.rec.last_time;
        out_data_nxt.flow_source       = tail.rec.source;
        out_data_nxt.flow_dest         = tail.rec.dest;
      end
    end
    if (!adv) begin
      cnt_nxt = cnt_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // dropped beat waiting in the result register
  assign out_drop = out_valid_r && (out_data_r.status == ST_DROPPED);

  // a drop only happens with every slot taken, and the count stays in range
  `FST_ASSERT_NOW(a_drop_when_full, out_drop, cnt_r == CNT_FULL, "event dropped with free slots")
  `FST_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CNT_FULL, "flow count above table size")

endmodule

### test/flow_statistics_table_tb.sv
module flow_statistics_table_tb;
  import fst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FLOW_SLOTS = DEFAULT_MAX_FLOWS;
  localparam int KEY_POOL = 300;
  localparam int HOT_KEYS = 64;
  localparam int BURST_ITEMS = 1000;
  localparam int HOLD_CYCLES = 800;
  localparam int HOLD_AFTER = 300;

  // event codes that only touch last time and total
  localparam logic [2:0] EV_OTHER = 3'd1;
  localparam logic [2:0] EV_RSVD5 = 3'd5;
  localparam logic [2:0] EV_RSVD6 = 3'd6;
  localparam logic [2:0] EV_RSVD7 = 3'd7;

  typedef struct {
    fst_in_t  ev;
    bit       typed;
    fst_out_t want;
  } stim_row_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  fst_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  fst_out_t out_data;

  // flow table mirror
  logic [31:0] flow_key_tbl [FLOW_SLOTS];
  fst_rec_t    flow_rec_tbl [FLOW_SLOTS];
  int unsigned flow_fill = 0;

  fst_out_t    pending_records[$];
  stim_row_t   directed_rows[$];
  logic [31:0] key_pool [KEY_POOL];
  bit          key_taken [logic [31:0]];
  logic [31:0] stamp_now = '0;
  int          fail_count = 0;
  int          results_seen = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          hold_done = 1'b0;

  flow_statistics_table #(
    .MAX_FLOWS(FLOW_SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [31:0] sat_inc32(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // look up or insert the flow, update its counters, return the record
  function automatic fst_out_t account_event(fst_in_t ev);
    fst_out_t    res;
    fst_rec_t    rec;
    fst_status_t st;
    int          slot;
    res = '0;
    slot = -1;
    for (int i = 0; i < flow_fill && slot < 0; i++) begin
      if (flow_key_tbl[i] == ev.flow_id) slot = i;
    end
    if (slot >= 0) begin
      st = ST_UPDATED;
    end else if (flow_fill < FLOW_SLOTS) begin
      slot = flow_fill;
      flow_key_tbl[slot] = ev.flow_id;
      rec = '0;
      rec.first_time = ev.timestamp;
      rec.source = ev.source_node;
      rec.dest = ev.dest_node;
      flow_rec_tbl[slot] = rec;
      flow_fill++;
      st = ST_INSERTED;
    end else begin
      // table full: event dropped, record fields stay zero
      res.status = ST_DROPPED;
      res.flows_known = 9'(flow_fill);
      return res;
    end
    rec = flow_rec_tbl[slot];
    rec.last_time = ev.timestamp;
    rec.total = sat_inc32(rec.total);
    case (ev.event_code)
      EV_SEND: begin
        rec.processed = sat_inc32(rec.processed);
        rec.sent = sat_inc32(rec.sent);
        if (rec.in_flight != IN_FLIGHT_MAX) rec.in_flight = rec.in_flight + 32'sd1;
      end
      EV_PROC: begin
        rec.processed = sat_inc32(rec.processed);
      end
      EV_RECV: begin
        rec.processed = sat_inc32(rec.processed);
        if (rec.in_flight != IN_FLIGHT_MIN) rec.in_flight = rec.in_flight - 32'sd1;
      end
      EV_LOST: begin
        rec.lost = sat_inc32(rec.lost);
        if (rec.in_flight != IN_FLIGHT_MIN) rec.in_flight = rec.in_flight - 32'sd1;
      end
      default: ;
    endcase
    flow_rec_tbl[slot] = rec;
    res.status = st;
    res.in_flight = rec.in_flight;
    res.packets_total = rec.total;
    res.packets_processed = rec.processed;
    res.packets_sent = rec.sent;
    res.packets_lost = rec.lost;
    res.first_time = rec.first_time;
    res.last_time = rec.last_time;
    res.flow_source = rec.source;
    res.flow_dest = rec.dest;
    res.flows_known = 9'(flow_fill);
    return res;
  endfunction

  function automatic fst_in_t trace_ev(logic [31:0] id, logic [2:0] code, logic [31:0] ts,
                                       logic [15:0] src, logic [15:0] dst);
    fst_in_t ev;
    ev.flow_id = id;
    ev.event_code = code;
    ev.timestamp = ts;
    ev.source_node = src;
    ev.dest_node = dst;
    return ev;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // random event on a given flow, biased toward send and receive
  function automatic fst_in_t pick_event(logic [31:0] key);
    logic [2:0]  code;
    logic [31:0] ts;
    int          r;
    r = $urandom_range(0, 9);
    if (r < 4) code = EV_SEND;
    else if (r < 5) code = EV_PROC;
    else if (r < 7) code = EV_RECV;
    else if (r < 8) code = EV_LOST;
    else code = 3'($urandom_range(0, 7));
    stamp_now = stamp_now + 32'($urandom_range(0, 5000));
    ts = ($urandom_range(0, 15) == 0) ? 32'($urandom) : stamp_now;
    return trace_ev(key, code, ts, 16'($urandom), 16'($urandom));
  endfunction

  // offer one beat, record its expectation once accepted
  task automatic send_event(fst_in_t ev, bit typed, fst_out_t want);
    fst_out_t pred;
    int       gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (!in_ready);
    pred = account_event(ev);
    pending_records.push_back(typed ? want : pred);
  endtask

  function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    fst_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_records.size() == 0) begin
        $display("%0t unexpected result beat: expected none, actual %h", $time, out_data);
        fail_count++;
      end else begin
        want = pending_records.pop_front();
        match_field("status", 32'(want.status), 32'(out_data.status));
        match_field("in_flight", want.in_flight, out_data.in_flight);
        match_field("packets_total", want.packets_total, out_data.packets_total);
        match_field("packets_processed", want.packets_processed, out_data.packets_processed);
        match_field("packets_sent", want.packets_sent, out_data.packets_sent);
        match_field("packets_lost", want.packets_lost, out_data.packets_lost);
        match_field("first_time", want.first_time, out_data.first_time);
        match_field("last_time", want.last_time, out_data.last_time);
        match_field("flow_source", 32'(want.flow_source), 32'(out_data.flow_source));
        match_field("flow_dest", 32'(want.flow_dest), 32'(out_data.flow_dest));
        match_field("flows_known", 32'(want.flows_known), 32'(out_data.flows_known));
      end
    end
  end

  // receiver: random stalls, one long hold-off to back the row up
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      stall = pick_gap(rx_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // stimulus
  initial begin
    logic [31:0] key;
    int          r;
    // extremes, every event code, new flows going negative in flight
    directed_rows.push_back('{trace_ev(32'h0, EV_SEND, 32'h0, 16'h0, 16'h0), 1'b1,
      fst_out_t'{ST_INSERTED, 32'sd1, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0,
                 16'h0, 16'h0, 9'd1}});
    directed_rows.push_back('{trace_ev(32'hFFFF_FFFF, EV_LOST, 32'hFFFF_FFFF, 16'hFFFF,
      16'hFFFF), 1'b1,
      fst_out_t'{ST_INSERTED, -32'sd1, 32'd1, 32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 9'd2}});
    // endpoints of an existing flow are not rewritten
    directed_rows.push_back('{trace_ev(32'h0, EV_RECV, 32'd5, 16'hFFFF, 16'hFFFF), 1'b1,
      fst_out_t'{ST_UPDATED, 32'sd0, 32'd2, 32'd2, 32'd1, 32'd0, 32'd0, 32'd5,
                 16'h0, 16'h0, 9'd2}});
    directed_rows.push_back('{trace_ev(32'h0, EV_OTHER, 32'h8000_0000, 16'h8000, 16'h7FFF),
      1'b0, '0});
    directed_rows.push_back('{trace_ev(32'h0, EV_RSVD5, 32'h7FFF_FFFF, 16'h1, 16'h2), 1'b0, '0});
    directed_rows.push_back('{trace_ev(32'h0, EV_RSVD6, 32'h0, 16'h0, 16'h0), 1'b0, '0});
    directed_rows.push_back('{trace_ev(32'h0, EV_RSVD7, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF),
      1'b0, '0});
    directed_rows.push_back('{trace_ev(32'hFFFF_FFFF, EV_PROC, 32'h1, 16'h0, 16'h0), 1'b0, '0});
    directed_rows.push_back('{trace_ev(32'hFFFF_FFFF, EV_SEND, 32'h2, 16'h0, 16'h0), 1'b0, '0});
    directed_rows.push_back('{trace_ev(32'hFFFF_FFFF, EV_SEND, 32'h3, 16'h0, 16'h0), 1'b0, '0});
    directed_rows.push_back('{trace_ev(32'h5555_AAAA, EV_RECV, 32'h5555_5555, 16'h5555,
      16'hAAAA), 1'b0, '0});
    directed_rows.push_back('{trace_ev(32'hAAAA_5555, EV_PROC, 32'hAAAA_AAAA, 16'hAAAA,
      16'h5555), 1'b0, '0});
    directed_rows.push_back('{trace_ev(32'h5555_AAAA, EV_LOST, 32'h5555_5556, 16'h0, 16'h0),
      1'b0, '0});
    directed_rows.push_back('{trace_ev(32'hAAAA_5555, EV_OTHER, 32'hAAAA_AAAB, 16'h0, 16'h0),
      1'b0, '0});
    directed_rows.push_back('{trace_ev(32'h8000_0001, EV_SEND, 32'h10, 16'h8000, 16'h0001),
      1'b0, '0});
    directed_rows.push_back('{trace_ev(32'h0000_0001, EV_SEND, 32'h11, 16'h0001, 16'h8000),
      1'b0, '0});

    // distinct random flow keys, none shared with the directed flows
    foreach (directed_rows[i]) key_taken[directed_rows[i].ev.flow_id] = 1'b1;
    foreach (key_pool[i]) begin
      do key = $urandom; while (key_taken.exists(key));
      key_taken[key] = 1'b1;
      key_pool[i] = key;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
    end

    // a hot set of flows, with a trickle of one-off flows
    for (int n = 0; n < BURST_ITEMS; n++) begin
      tx_calm = (n % 400) >= 300;
      r = $urandom_range(0, 9);
      key = (r == 0) ? 32'($urandom) : key_pool[$urandom_range(0, HOT_KEYS - 1)];
      send_event(pick_event(key), 1'b0, '0);
    end

    // the whole pool: fills the table, then unknown flows get dropped
    for (int n = 0; n < BURST_ITEMS; n++) begin
      tx_calm = (n % 400) >= 300;
      r = $urandom_range(0, 19);
      if (r < 3) key = 32'($urandom);
      else if (r < 8) key = key_pool[$urandom_range(0, HOT_KEYS - 1)];
      else key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      send_event(pick_event(key), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain, then watch for stray beats over one more pass of the row
    while (pending_records.size() != 0) @(posedge clk);
    repeat (FLOW_SLOTS + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### flow_statistics_table.f
+incdir+rtl
rtl/fst_pkg.sv
rtl/fst_cell.sv
rtl/flow_statistics_table.sv
test/flow_statistics_table_tb.sv
